>>> design/ialu_pkg.sv
// Shared types, operation codes and constants for the integer ALU.
package ialu_pkg;

    localparam int DATA_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int DIV_W     = 32;

    typedef enum logic [4:0] {
        OP_COPY = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3,
        OP_DIV = 5'd4, OP_UDIV = 5'd5, OP_MOD = 5'd6, OP_UMOD = 5'd7,
        OP_SHL = 5'd8, OP_SHR = 5'd9, OP_USHR = 5'd10, OP_AND = 5'd11,
        OP_OR = 5'd12, OP_XOR = 5'd13, OP_NEG = 5'd14, OP_NOT = 5'd15,
        OP_LT = 5'd16, OP_LE = 5'd17, OP_EQ = 5'd18, OP_NE = 5'd19,
        OP_ULT = 5'd20, OP_ULE = 5'd21, OP_SEXT8 = 5'd22, OP_SEXT16 = 5'd23,
        OP_ZEXT = 5'd24, OP_TRUNC = 5'd25
    } op_t;

    // result source class chosen by the front end
    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2,
        CLS_REM    = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic        neg_res;              // negate divider result
        logic [31:0] simple;               // result for simple ops
        logic [31:0] a;                    // mul operand or divider magnitude
        logic [31:0] b;
    } job_t;

endpackage

>>> design/ir_integer_alu_top.sv
// Top level of the 32-bit integer execute unit.
//  channel | dir | tdata (low bit up)                       | tuser
//  s_      | in  | func[4:0] a[36:5] b[68:37] dbytes[70:69] | dest_signed
//  m_      | out | result[31:0]                             | -
// One item per cycle sustained while m_ is not stalled. An item passes the queue,
// the input register, the divider (a DIV_W-stage pipeline resolving one quotient
// bit a stage) and the output register. Reset clears all valid state synchronously.
// A stall on m_ freezes the whole back pipeline once its last stage holds an item,
// then the queue absorbs up to FIFO_DEPTH items before s_tready drops.
module ir_integer_alu_top #(
    parameter int FIFO_DEPTH = ialu_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func, operand_a, operand_b, dest_bytes, pad
    input  logic        s_tuser,   // dest_signed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result
);
    import ialu_pkg::*;

    job_t fjob, qjob;
    logic qv, qr;

    ialu_front u_front (
        .func(s_tdata[4:0]), .operand_a(s_tdata[36:5]), .operand_b(s_tdata[68:37]),
        .dest_signed(s_tuser), .dest_bytes(s_tdata[70:69]), .job(fjob)
    );

    ialu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk, .aresetn, .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(fjob),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qjob)
    );

    ialu_back u_back (
        .aclk, .aresetn, .in_valid(qv), .in_ready(qr), .in_job(qjob),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_result(m_tdata)
    );
endmodule

>>> design/ialu_front.sv
// Front end: decodes an item, computes the simple ops, preps divide operands.
module ialu_front (
    input  logic [4:0]          func,
    input  logic [31:0]         operand_a,
    input  logic [31:0]         operand_b,
    input  logic                dest_signed,
    input  logic [1:0]          dest_bytes,
    output ialu_pkg::job_t      job
);
    import ialu_pkg::*;

    logic [4:0]  s;
    logic        slt_ab, slt_ba;
    logic        na, nb;
    logic [31:0] ua, ub;

    always_comb begin
        s      = operand_b[4:0];
        slt_ab = (operand_a ^ 32'h8000_0000) < (operand_b ^ 32'h8000_0000);
        slt_ba = (operand_b ^ 32'h8000_0000) < (operand_a ^ 32'h8000_0000);
        na     = operand_a[31];
        nb     = operand_b[31];
        ua     = na ? (32'd0 - operand_a) : operand_a;
        ub     = nb ? (32'd0 - operand_b) : operand_b;

        job.cls     = CLS_SIMPLE;
        job.neg_res = 1'b0;
        job.simple  = 32'd0;
        job.a       = operand_a;
        job.b       = operand_b;
        case (func)
            OP_COPY, OP_ZEXT: job.simple = operand_a;
            OP_ADD:  job.simple = operand_a + operand_b;
            OP_SUB:  job.simple = operand_a - operand_b;
            OP_MUL:  job.cls = CLS_MUL;
            OP_DIV: begin
                job.cls = CLS_DIV; job.a = ua; job.b = ub; job.neg_res = na ^ nb;
            end
            OP_UDIV: job.cls = CLS_DIV;
            OP_MOD: begin
                job.cls = CLS_REM; job.a = ua; job.b = ub; job.neg_res = na;
            end
            OP_UMOD: job.cls = CLS_REM;
            OP_SHL:  job.simple = operand_a << s;
            OP_SHR:  job.simple = dest_signed ? 32'($signed(operand_a) >>> s)
                                              : operand_a >> s;
            OP_USHR: job.simple = operand_a >> s;
            OP_AND:  job.simple = operand_a & operand_b;
            OP_OR:   job.simple = operand_a | operand_b;
            OP_XOR:  job.simple = operand_a ^ operand_b;
            OP_NEG:  job.simple = 32'd0 - operand_a;
            OP_NOT:  job.simple = {31'd0, operand_a == 32'd0};
            OP_LT:   job.simple = {31'd0, slt_ab};
            OP_LE:   job.simple = {31'd0, !slt_ba};
            OP_EQ:   job.simple = {31'd0, operand_a == operand_b};
            OP_NE:   job.simple = {31'd0, operand_a != operand_b};
            OP_ULT:  job.simple = {31'd0, operand_a < operand_b};
            OP_ULE:  job.simple = {31'd0, operand_a <= operand_b};
            OP_SEXT8:  job.simple = {{24{operand_a[7]}}, operand_a[7:0]};
            OP_SEXT16: job.simple = {{16{operand_a[15]}}, operand_a[15:0]};
            OP_TRUNC: begin
                case (dest_bytes)
                    2'd0:    job.simple = {24'd0, operand_a[7:0]};
                    2'd1:    job.simple = {16'd0, operand_a[15:0]};
                    default: job.simple = operand_a;
                endcase
            end
            default: job.simple = 32'd0;
        endcase
    end
endmodule

>>> design/ialu_fifo.sv
// Short queue of decoded jobs between front and back end.
module ialu_fifo #(
    parameter int DEPTH = ialu_pkg::FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  ialu_pkg::job_t     wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output ialu_pkg::job_t     rd_data
);
    import ialu_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t          mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

>>> design/ialu_back.sv
// Back end: pipelined radix-2 divider and multiplier with output register.
module ialu_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ialu_pkg::job_t  in_job,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     out_result
);
    import ialu_pkg::*;

    localparam int W = DIV_W;

    // stage 0 is the input register; stages 1..W each resolve one quotient bit
    logic          v_reg   [W+1];
    cls_t          cls_reg [W+1];
    logic          neg_reg [W+1];
    logic [31:0]   q_reg   [W+1];   // dividend shifting into quotient
    logic [31:0]   r_reg   [W+1];
    logic [31:0]   d_reg   [W+1];
    logic          z_reg   [W+1];   // zero divisor
    logic [31:0]   res_reg;
    logic          ov_reg;
    logic          adv;
    logic          out_free;
    logic [31:0]   fin, mag;

    // output slot can take a new value this cycle
    assign out_free = !ov_reg || out_ready;
    // pipeline moves if the output slot frees up or the last stage is a bubble
    assign adv      = out_free || !v_reg[W];
    assign in_ready = adv;
    assign out_valid  = ov_reg;
    assign out_result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= W; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= W; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cls_reg[0] <= in_job.cls;
            neg_reg[0] <= in_job.neg_res;
            z_reg[0]   <= in_job.b == 32'd0;
            d_reg[0]   <= in_job.b;
            r_reg[0]   <= 32'd0;
            // mul result rides the quotient lane
            case (in_job.cls)
                CLS_SIMPLE: q_reg[0] <= in_job.simple;
                CLS_MUL:    q_reg[0] <= in_job.a * in_job.b;
                default:    q_reg[0] <= in_job.a;
            endcase
            for (int i = 1; i <= W; i++) begin
                logic [32:0] t;
                logic        div;
                t = 33'(r_reg[i-1]) << 1;
                t = t | 33'(q_reg[i-1][31]);
                div = cls_reg[i-1] == CLS_DIV || cls_reg[i-1] == CLS_REM;
                cls_reg[i] <= cls_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                z_reg[i]   <= z_reg[i-1];
                d_reg[i]   <= d_reg[i-1];
                if (div) begin
                    if (t >= {1'b0, d_reg[i-1]}) begin
                        r_reg[i] <= 32'(t - {1'b0, d_reg[i-1]});
                        q_reg[i] <= {q_reg[i-1][30:0], 1'b1};
                    end else begin
                        r_reg[i] <= t[31:0];
                        q_reg[i] <= {q_reg[i-1][30:0], 1'b0};
                    end
                end else begin
                    r_reg[i] <= r_reg[i-1];
                    q_reg[i] <= q_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        mag = (cls_reg[W] == CLS_REM) ? r_reg[W] : q_reg[W];
        case (cls_reg[W])
            CLS_DIV, CLS_REM:
                fin = z_reg[W] ? 32'd0 : (neg_reg[W] ? 32'd0 - mag : mag);
            default: fin = q_reg[W];
        endcase
    end

    // hold a waiting result until it transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (out_free) ov_reg <= v_reg[W];
    end

    always_ff @(posedge aclk) begin
        if (out_free) res_reg <= fin;
    end
endmodule

>>> dv/ir_integer_alu_top_tb.sv
// Testbench for the 32-bit integer execute unit: directed and random items, scoreboard check.
`timescale 1ns / 100ps

class alu_scoreboard;
    logic [31:0] results_q[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    static function logic [31:0] compute(logic [4:0] func, logic [31:0] a, logic [31:0] b,
                                         logic sgn, logic [1:0] dbytes);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        logic [4:0]  sh;
        sh = b[4:0];
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        case (func)
            ialu_pkg::OP_COPY:   return a;
            ialu_pkg::OP_ADD:    return a + b;
            ialu_pkg::OP_SUB:    return a - b;
            ialu_pkg::OP_MUL:    return a * b;
            ialu_pkg::OP_DIV: begin
                if (ub == 0) return 0;
                q = ua / ub;
                return (a[31] != b[31]) ? -q : q;
            end
            ialu_pkg::OP_UDIV:   return (b != 0) ? a / b : 0;
            ialu_pkg::OP_MOD: begin
                if (ub == 0) return 0;
                q = ua % ub;
                return a[31] ? -q : q;
            end
            ialu_pkg::OP_UMOD:   return (b != 0) ? a % b : 0;
            ialu_pkg::OP_SHL:    return a << sh;
            ialu_pkg::OP_SHR:    return sgn ? 32'($signed(a) >>> sh) : a >> sh;
            ialu_pkg::OP_USHR:   return a >> sh;
            ialu_pkg::OP_AND:    return a & b;
            ialu_pkg::OP_OR:     return a | b;
            ialu_pkg::OP_XOR:    return a ^ b;
            ialu_pkg::OP_NEG:    return -a;
            ialu_pkg::OP_NOT:    return {31'd0, a == 0};
            ialu_pkg::OP_LT:     return {31'd0, $signed(a) < $signed(b)};
            ialu_pkg::OP_LE:     return {31'd0, $signed(a) <= $signed(b)};
            ialu_pkg::OP_EQ:     return {31'd0, a == b};
            ialu_pkg::OP_NE:     return {31'd0, a != b};
            ialu_pkg::OP_ULT:    return {31'd0, a < b};
            ialu_pkg::OP_ULE:    return {31'd0, a <= b};
            ialu_pkg::OP_SEXT8:  return {{24{a[7]}}, a[7:0]};
            ialu_pkg::OP_SEXT16: return {{16{a[15]}}, a[15:0]};
            ialu_pkg::OP_ZEXT:   return a;
            ialu_pkg::OP_TRUNC: begin
                if (dbytes == 0) return a & 32'hff;
                if (dbytes == 1) return a & 32'hffff;
                return a;
            end
            default:             return 0;
        endcase
    endfunction

    function void note_input(logic [71:0] tdata, logic sgn);
        results_q.push_back(compute(tdata[4:0], tdata[36:5], tdata[68:37], sgn,
                                    tdata[70:69]));
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] want;
        if (results_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = results_q.pop_front();
        if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            errors++;
        end
    endfunction
endclass

module ir_integer_alu_top_tb;
    localparam int LIMIT_CYCLES = 400000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;  // func[4:0] a[36:5] b[68:37] dbytes[70:69] pad
    logic        s_tuser = 0;   // dest_signed
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;       // result

    int  send_idle_pct = 32;
    int  recv_idle_pct = 67;
    bit  hold_off = 0;
    int  cycles = 0;
    alu_scoreboard sb = new();

    ir_integer_alu_top u_top (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall, long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser);

    task automatic send_item(logic [4:0] func, logic [31:0] a, logic [31:0] b,
                             logic sgn, logic [1:0] dbytes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {1'b0, dbytes, b, a, func};
        s_tuser  <= sgn;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'hffff_ffff;
            2: return $urandom_range(3);
            3: return -$urandom_range(3);
            4: return $urandom_range(300);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(int n);
        logic [4:0] func;
        repeat (n) begin
            func = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 26)) : 5'($urandom_range(25));
            send_item(func, pick_operand(), pick_operand(), 1'($urandom),
                      2'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.results_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: zero divisors, overflow division, shift masking, trunc sizes
        send_item(ialu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1, 2);
        send_item(ialu_pkg::OP_MOD, 32'h8000_0000, 32'hffff_ffff, 1, 2);
        send_item(ialu_pkg::OP_DIV, 32'd7, 32'd0, 1, 2);
        send_item(ialu_pkg::OP_UDIV, 32'd7, 32'd0, 0, 2);
        send_item(ialu_pkg::OP_MOD, 32'hffff_fff9, 32'd0, 1, 2);
        send_item(ialu_pkg::OP_UMOD, 32'hffff_ffff, 32'd0, 0, 2);
        send_item(ialu_pkg::OP_DIV, -32'd7, 32'd2, 1, 0);
        send_item(ialu_pkg::OP_MOD, -32'd7, 32'd2, 1, 0);
        send_item(ialu_pkg::OP_MOD, 32'd7, -32'd2, 1, 0);
        send_item(ialu_pkg::OP_SHL, 32'h1, 32'hffff_ffe1, 0, 0);
        send_item(ialu_pkg::OP_SHR, 32'h8000_0000, 32'd31, 1, 0);
        send_item(ialu_pkg::OP_SHR, 32'h8000_0000, 32'd31, 0, 0);
        send_item(ialu_pkg::OP_USHR, 32'hffff_ffff, 32'd63, 1, 0);
        send_item(ialu_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
        send_item(ialu_pkg::OP_LE, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        send_item(ialu_pkg::OP_ULE, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
        send_item(ialu_pkg::OP_NOT, 32'd0, 32'hffff_ffff, 1, 3);
        send_item(ialu_pkg::OP_SEXT8, 32'h0000_0080, 32'd0, 0, 0);
        send_item(ialu_pkg::OP_SEXT16, 32'h1234_8000, 32'd0, 0, 0);
        send_item(ialu_pkg::OP_TRUNC, 32'hdead_beef, 32'd0, 0, 0);
        send_item(ialu_pkg::OP_TRUNC, 32'hdead_beef, 32'd0, 0, 1);
        send_item(ialu_pkg::OP_TRUNC, 32'hdead_beef, 32'd0, 0, 3);
        send_item(5'd31, 32'hffff_ffff, 32'hffff_ffff, 1, 3);
        random_items(650);
        // hold off the receiver long enough to fill the block
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            random_items(80);
        join
        send_idle_pct = 67;
        recv_idle_pct = 32;
        random_items(580);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(570);
        drain();
        if (sb.errors == 0 && sb.results_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
